@@ sv/rgbc_pkg.sv @@
// rgbc_pkg: shared types, constants and register codes for the rgb 3x3 convolution block
// no dependencies; imported by rgbc_mac_cell and rgb_convolution_3x3
`timescale 1ns / 1ps

package rgbc_pkg;

  // pixel layout: three 8-bit channels, red in the low byte
  localparam int PIX_W       = 24;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;

  // kernel geometry and coefficient layout
  localparam int KERNEL_SIZE = 3;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int TAP_W       = 16;
  localparam int KROW_W      = KERNEL_SIZE * TAP_W;

  // frame geometry
  localparam int MAX_LINE_WIDTH_DEF = 2048;
  localparam int DIM_W       = 12;
  localparam int ROW_W       = DIM_W + 1;

  // configuration port
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_LSB = 3;

  // register reset values
  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = DIM_W'(480);
  localparam logic [KROW_W-1:0] KTOP_RST         = 48'hFFFF_0000_0001;
  localparam logic [KROW_W-1:0] KMID_RST         = 48'h0000_0000_0000;
  localparam logic [KROW_W-1:0] KBOT_RST         = 48'h0001_0000_FFFF;

  // register index codes (byte address is 8 times the index)
  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_KERNEL_TOP   = 3'd2,
    REG_KERNEL_MID   = 3'd3,
    REG_KERNEL_BOT   = 3'd4
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // control that travels along the mac chain with each job
  typedef struct packed {
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

@@ sv/rgbc_ram.sv @@
// rgbc_ram: generic single-write, single-read memory with registered read data
// no dependencies; used for the two line stores
`timescale 1ns / 1ps

module rgbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/rgbc_mac_cell.sv @@
// rgbc_mac_cell: one kernel tap of the convolution chain, multiply-accumulate per channel
// depends on rgbc_pkg
`timescale 1ns / 1ps

module rgbc_mac_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv_i,
  input  rgbc_pkg::mac_ctl_t       ctl_i,
  input  rgbc_pkg::pixel_t         acc_i,
  input  rgbc_pkg::pixel_t         pix_i,
  input  logic [rgbc_pkg::CH_W-1:0] coef_i,
  output rgbc_pkg::mac_ctl_t       ctl_o,
  output rgbc_pkg::pixel_t         acc_o
);
  import rgbc_pkg::*;

  logic [2*CH_W-1:0] prod [NUM_CH];
  pixel_t            acc_nxt;
  mac_ctl_t          ctl_r;
  pixel_t            acc_r;

  // results wrap to 8 bits, so only the low coefficient byte matters
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = pix_i[ch*CH_W +: CH_W] * coef_i;
      acc_nxt[ch*CH_W +: CH_W] = acc_i[ch*CH_W +: CH_W] + prod[ch][CH_W-1:0];
    end
  end

  // job control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv_i) begin
      ctl_r <= ctl_i;
    end
  end

  // partial sums
  always_ff @(posedge clk) begin
    if (adv_i) begin
      acc_r <= acc_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;

endmodule

@@ sv/rgb_convolution_3x3.sv @@
// rgb_convolution_3x3: streaming 3x3 convolution of 24-bit rgb pixels, top level
// depends on rgbc_pkg, rgbc_ram and rgbc_mac_cell
`timescale 1ns / 1ps

// Takes one pixel per clock in raster order while in_stall is low and gives one result
// per clock once the pipeline is full, unless the output stalls; the rate is set by the
// line stores, which take one read and one write per pixel. The result for a pixel
// comes out with the input item that lies one row plus one pixel after it, so
// frame_width + 1 pad items after the frame flush the last results; frame_last marks
// the final pixel. On the transfer of the causing item the masked 3x3 window is
// registered in the job stage, then passes the nine tap cells and the output register.
// A skid register behind the chain absorbs one result when the output stalls, and the
// input stall is a register. Neighbors outside the frame are forced to zero, so the
// line stores need no clearing after reset or a geometry change. Writing frame_width
// or frame_height restarts the frame. The user must write configuration only while
// the block is idle; the block itself does not enforce this.
module rgb_convolution_3x3 #(
  parameter int MAX_LINE_WIDTH = rgbc_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rgbc_pkg::PIX_W-1:0]       in_pixel_in,
  input  logic                             in_pad_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rgbc_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                             out_frame_last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgbc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rgbc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import rgbc_pkg::*;

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CW = (WW > DIM_W) ? WW : DIM_W;
  localparam int TW = ROW_W + 1;

  // configuration registers
  logic [DIM_W-1:0]  fw_r;
  logic [DIM_W-1:0]  fh_r;
  logic [KROW_W-1:0] kern_r [KERNEL_SIZE];
  logic              cfg_wr;
  cfg_reg_t          cfg_idx;
  logic              restart;

  // geometry
  logic [WW-1:0]     w_eff;
  logic [CW-1:0]     fw_ext;
  logic [DIM_W-1:0]  h_eff;

  // frame position and window
  logic [AW-1:0]     c_r;
  logic [AW-1:0]     c_nxt;
  logic [ROW_W-1:0]  r_r;
  logic [ROW_W-1:0]  r_nxt;
  logic [WW-1:0]     c_inc;
  pixel_t            win_r [KERNEL_SIZE][KERNEL_SIZE];
  pixel_t            newcol [KERNEL_SIZE];
  pixel_t            pix;
  logic              acc;
  logic              drop;
  logic              step;
  logic              p1;
  logic              p2;
  logic              is_last;
  logic [TW-1:0]     row_off;
  logic [TW-1:0]     row_t;
  logic              row_ok [KERNEL_SIZE];
  logic              col_ok [KERNEL_SIZE];
  pixel_t            src;

  // line stores
  pixel_t            up_rd;
  pixel_t            lo_rd;
  pixel_t            up_q;
  pixel_t            lo_q;
  logic              byp_r;
  pixel_t            byp_up_r;
  pixel_t            byp_lo_r;

  // job stage and mac chain
  logic              adv;
  logic              job_v_r;
  logic              job_last_r;
  pixel_t            job_pix_nxt [TAPS];
  pixel_t            job_pix_r [TAPS];
  logic [CH_W-1:0]   coef [TAPS];
  mac_ctl_t          ctl_ch [TAPS+1];
  pixel_t            acc_ch [TAPS+1];

  // output register and skid
  logic              out_valid_r;
  pixel_t            out_pix_r;
  logic              out_last_r;
  logic              skid_valid_r;
  pixel_t            skid_pix_r;
  logic              skid_last_r;
  logic              out_take;

  // apb decode, pready is always high
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
  assign restart = cfg_wr &&
                   (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= FRAME_WIDTH_RST;
      fh_r      <= FRAME_HEIGHT_RST;
      kern_r[0] <= KTOP_RST;
      kern_r[1] <= KMID_RST;
      kern_r[2] <= KBOT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  fw_r      <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: fh_r      <= pwdata[DIM_W-1:0];
        REG_KERNEL_TOP:   kern_r[0] <= pwdata[KROW_W-1:0];
        REG_KERNEL_MID:   kern_r[1] <= pwdata[KROW_W-1:0];
        REG_KERNEL_BOT:   kern_r[2] <= pwdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(fw_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(fh_r);
      REG_KERNEL_TOP:   prdata = CFG_DATA_W'(kern_r[0]);
      REG_KERNEL_MID:   prdata = CFG_DATA_W'(kern_r[1]);
      REG_KERNEL_BOT:   prdata = CFG_DATA_W'(kern_r[2]);
      default:          prdata = '0;
    endcase
  end

  // effective geometry: width clamped to 1..max, height at least 1
  always_comb begin
    fw_ext = CW'(fw_r);
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (fw_ext > CW'(MAX_LINE_WIDTH)) begin
      w_eff = WW'(MAX_LINE_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    h_eff = (fh_r == '0) ? DIM_W'(1) : fh_r;
  end

  // line store read data, forwarded when the same entry was just written
  assign up_q = byp_r ? byp_up_r : up_rd;
  assign lo_q = byp_r ? byp_lo_r : lo_rd;

  // item decode
  always_comb begin
    acc     = in_valid & ~in_stall;
    pix     = in_pad_item ? '0 : in_pixel_in;
    drop    = in_pad_item && (c_r == '0) && (r_r == '0);
    step    = acc & ~drop;
    // row start finishes the last pixel of the row two back
    p1      = (c_r == '0) && (r_r >= ROW_W'(2));
    p2      = (c_r != '0) && (r_r != '0);
    is_last = p1 && (r_r == ROW_W'(h_eff) + ROW_W'(1));
    newcol[0] = up_q;
    newcol[1] = lo_q;
    newcol[2] = pix;
  end

  // border masking of the window for the job
  always_comb begin
    row_off = p1 ? TW'(3) : TW'(2);
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      row_t     = TW'(r_r) + TW'(i);
      row_ok[i] = (row_t >= row_off) && (row_t < TW'(h_eff) + row_off);
    end
    col_ok[0] = p1 ? (w_eff >= WW'(2)) : (WW'(c_r) >= WW'(2));
    col_ok[1] = 1'b1;
    col_ok[2] = ~p1;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        if (j == 0) begin
          src = win_r[i][1];
        end else if (j == 1) begin
          src = win_r[i][2];
        end else begin
          src = newcol[i];
        end
        job_pix_nxt[i*KERNEL_SIZE + j] = (row_ok[i] && col_ok[j]) ? src : '0;
      end
    end
  end

  // next frame position
  always_comb begin
    c_inc = WW'(c_r) + WW'(1);
    c_nxt = c_r;
    r_nxt = r_r;
    if (restart) begin
      c_nxt = '0;
      r_nxt = '0;
    end else if (step) begin
      if (is_last) begin
        c_nxt = '0;
        r_nxt = '0;
      end else if (c_inc >= w_eff) begin
        c_nxt = '0;
        r_nxt = r_r + ROW_W'(1);
      end else begin
        c_nxt = c_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= '0;
      r_r <= '0;
    end else begin
      c_r <= c_nxt;
      r_r <= r_nxt;
    end
  end

  // window columns shift left, new column from the stores and the input
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
        win_r[i][2] <= newcol[i];
      end
    end
  end

  // line stores: upper takes the old lower row, lower takes the new pixel
  rgbc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (step),
    .waddr (c_r),
    .wdata (lo_q),
    .raddr (c_nxt),
    .rdata (up_rd)
  );

  rgbc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_lower (
    .clk   (clk),
    .we    (step),
    .waddr (c_r),
    .wdata (pix),
    .raddr (c_nxt),
    .rdata (lo_rd)
  );

  // same-address forwarding for single-pixel rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= step && (c_r == c_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byp_up_r <= lo_q;
      byp_lo_r <= pix;
    end
  end

  // whole chain moves unless the skid holds a result
  assign adv      = ~skid_valid_r;
  assign in_stall = skid_valid_r;

  // job stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
    end else if (adv) begin
      job_v_r <= step & (p1 | p2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_last_r <= is_last;
      job_pix_r  <= job_pix_nxt;
    end
  end

  // low coefficient byte of each tap
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        coef[i*KERNEL_SIZE + j] = kern_r[i][j*TAP_W +: CH_W];
      end
    end
  end

  assign ctl_ch[0] = '{valid: job_v_r, last: job_last_r};
  assign acc_ch[0] = '0;

  // chain of tap cells, each pixel delayed to meet its cell
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    pixel_t tap_pix;

    if (k == 0) begin : g_direct
      assign tap_pix = job_pix_r[0];
    end else begin : g_skew
      pixel_t sk_r [k];

      always_ff @(posedge clk) begin
        if (adv) begin
          sk_r[0] <= job_pix_r[k];
          for (int d = 1; d < k; d++) begin
            sk_r[d] <= sk_r[d-1];
          end
        end
      end

      assign tap_pix = sk_r[k-1];
    end

    rgbc_mac_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv_i  (adv),
      .ctl_i  (ctl_ch[k]),
      .acc_i  (acc_ch[k]),
      .pix_i  (tap_pix),
      .coef_i (coef[k]),
      .ctl_o  (ctl_ch[k+1]),
      .acc_o  (acc_ch[k+1])
    );
  end

  // output register and skid control
  assign out_take = out_valid_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= ctl_ch[TAPS].valid;
    end else if (ctl_ch[TAPS].valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // output register and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_pix_r  <= skid_pix_r;
        out_last_r <= skid_last_r;
      end
    end else if (!out_valid_r || out_take) begin
      out_pix_r  <= acc_ch[TAPS];
      out_last_r <= ctl_ch[TAPS].last;
    end else begin
      skid_pix_r  <= acc_ch[TAPS];
      skid_last_r <= ctl_ch[TAPS].last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

  // the skid only fills while the output register is held
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a held output");

  // column position stays inside the active row
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(c_r) < w_eff)
    else $error("column position beyond frame width");

  // the final pixel of a frame restarts the position counters
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_last) |=> (c_r == '0 && r_r == '0))
    else $error("frame end did not restart the frame");

  // a pad item before the first pixel yields no job
  a_drop_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && drop) |=> !job_v_r)
    else $error("dropped pad item produced a job");

  // row position never runs past the flush rows
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    r_r <= ROW_W'(h_eff) + ROW_W'(1))
    else $error("row position beyond frame flush");

endmodule
